>>> rtl/core/mcds_pkg.sv
package mcds_pkg;

   localparam int MAX_SLOTS   = 64;
   localparam int CREDIT_BITS = 16;

   localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int COUNT_W = $clog2(MAX_SLOTS + 1);

   localparam int COMMAND_W = 1;
   localparam int CREDIT_W  = 16;
   localparam int SERVED_W  = 7;
   localparam int NUM_W     = (SLOT_W + 1 > SERVED_W) ? SLOT_W + 1 : SERVED_W;

   localparam logic [COMMAND_W-1:0] CMD_LOAD  = 1'b0;
   localparam logic [COMMAND_W-1:0] CMD_SERVE = 1'b1;

   typedef logic [CREDIT_BITS-1:0] credit_type;
   typedef logic [SLOT_W-1:0]      slot_idx_type;

   typedef struct packed {
      logic         clear;
      logic         step;
      logic         live;
      slot_idx_type idx;
   } track_ctl_type;

   typedef struct packed {
      logic         found;
      credit_type   best;
      slot_idx_type idx;
   } track_sts_type;

   function automatic logic [SERVED_W-1:0] slot_number(input slot_idx_type idx);
      logic [NUM_W-1:0] num;
      num = NUM_W'(idx) + NUM_W'(1);
      return num[SERVED_W-1:0];
   endfunction

endpackage

>>> rtl/core/mcds_req_if.sv
interface mcds_req_if import mcds_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [COMMAND_W-1:0] command;
   logic [CREDIT_W-1:0]  credit;

   modport source (output valid, command, credit, input ready);
   modport sink   (input valid, command, credit, output ready);
endinterface

>>> rtl/core/mcds_rsp_if.sv
interface mcds_rsp_if import mcds_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SERVED_W-1:0] served_slot;
   logic                empty_res;

   modport source (output valid, served_slot, empty_res, input ready);
   modport sink   (input valid, served_slot, empty_res, output ready);
endinterface

>>> rtl/core/mcds_credit_ram.sv
module mcds_credit_ram import mcds_pkg::*; (
   input  logic         clock,
   input  logic         wr_en,
   input  slot_idx_type wr_addr,
   input  credit_type   wr_data,
   input  slot_idx_type rd_addr,
   output credit_type   rd_data
);

   credit_type mem [MAX_SLOTS];
   credit_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/mcds_max_track.sv
module mcds_max_track import mcds_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  track_ctl_type ctl,
   input  credit_type    data,
   output track_sts_type sts
);

   logic         found_ff, found_in;
   credit_type   best_ff, best_in;
   slot_idx_type idx_ff, idx_in;
   logic         take;

   // shared comparator
   assign take = ctl.step && ctl.live && (!found_ff || (data > best_ff));

   always_comb begin
      found_in = found_ff;
      best_in  = best_ff;
      idx_in   = idx_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         best_in  = data;
         idx_in   = ctl.idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      best_ff <= best_in;
      idx_ff  <= idx_in;
   end

   assign sts.found = found_ff;
   assign sts.best  = best_ff;
   assign sts.idx   = idx_ff;

endmodule

>>> rtl/core/max_credit_decrement_scheduler_core.sv
// load transaction: written on accept, next transaction may follow in the next cycle
// serve transaction: ST_SCAN, then ST_DRAIN, then ST_FINISH registers the result;
//   next accept back in ST_IDLE, at the earliest as the result is taken; the scan goes
//   one slot per cycle through the single credit comparator fed by the credit ram read port
// not ready while a serve scans, or while a finished result waits and is not taken
// reset clears live bits, load count and control state; the credit ram is not cleared
module max_credit_decrement_scheduler_core import mcds_pkg::*; (
   input logic        clock,
   input logic        reset,
   mcds_req_if.sink   req_if,
   mcds_rsp_if.source rsp_if
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  slots_loaded_ff, slots_loaded_in;
   logic [MAX_SLOTS-1:0] slot_live_ff, slot_live_in;
   slot_idx_type        scan_idx_ff, scan_idx_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic                cmp_live_ff, cmp_live_in;
   slot_idx_type        cmp_idx_ff, cmp_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SERVED_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                rsp_empty_ff, rsp_empty_in;

   logic          req_accept;
   logic          wr_en;
   slot_idx_type  wr_addr;
   credit_type    wr_data;
   credit_type    rd_data;
   track_ctl_type track_ctl;
   track_sts_type track_sts;

   mcds_credit_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   mcds_max_track u_track (
      .clock (clock),
      .reset (reset),
      .ctl   (track_ctl),
      .data  (rd_data),
      .sts   (track_sts)
   );

   assign req_if.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign req_accept   = req_if.valid && req_if.ready;

   assign track_ctl.clear = req_accept && (req_if.command == CMD_SERVE);
   assign track_ctl.step  = cmp_valid_ff;
   assign track_ctl.live  = cmp_live_ff;
   assign track_ctl.idx   = cmp_idx_ff;

   always_comb begin
      state_in        = state_ff;
      slots_loaded_in = slots_loaded_ff;
      slot_live_in    = slot_live_ff;
      scan_idx_in     = scan_idx_ff;
      cmp_valid_in    = 1'b0;
      cmp_live_in     = slot_live_ff[scan_idx_ff];
      cmp_idx_in      = scan_idx_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      rsp_slot_in     = rsp_slot_ff;
      rsp_empty_in    = rsp_empty_ff;
      wr_en           = 1'b0;
      wr_addr         = slots_loaded_ff[SLOT_W-1:0];
      wr_data         = CREDIT_BITS'(req_if.credit);
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_if.command == CMD_LOAD) begin
                  if (slots_loaded_ff < COUNT_W'(MAX_SLOTS)) begin
                     wr_en = 1'b1;
                     slot_live_in[slots_loaded_ff[SLOT_W-1:0]] = 1'b1;
                     slots_loaded_in = slots_loaded_ff + COUNT_W'(1);
                  end
               end else begin
                  scan_idx_in = '0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmp_valid_in = 1'b1;
            if (scan_idx_ff == SLOT_W'(MAX_SLOTS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + SLOT_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            if (track_sts.found) begin
               rsp_slot_in  = slot_number(track_sts.idx);
               rsp_empty_in = 1'b0;
               wr_en        = 1'b1;
               wr_addr      = track_sts.idx;
               wr_data      = track_sts.best - CREDIT_BITS'(1);
               if (track_sts.best <= CREDIT_BITS'(1)) begin
                  slot_live_in[track_sts.idx] = 1'b0;
               end
            end else begin
               rsp_slot_in  = '0;
               rsp_empty_in = 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         slots_loaded_ff <= '0;
         slot_live_ff    <= '0;
         scan_idx_ff     <= '0;
         cmp_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         slots_loaded_ff <= slots_loaded_in;
         slot_live_ff    <= slot_live_in;
         scan_idx_ff     <= scan_idx_in;
         cmp_valid_ff    <= cmp_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      cmp_live_ff  <= cmp_live_in;
      cmp_idx_ff   <= cmp_idx_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.served_slot = rsp_slot_ff;
   assign rsp_if.empty_res   = rsp_empty_ff;

   a_serve_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_if.command == CMD_SERVE)) |=> !rsp_if.valid)
      else $error("result raised right after serve accept");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      slots_loaded_ff <= COUNT_W'(MAX_SLOTS))
      else $error("load count beyond slot count");

   a_best_is_live: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && track_sts.found) |-> slot_live_ff[track_sts.idx])
      else $error("served slot not live");

   a_ready_rsp_free: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("ready while result pending");

endmodule

>>> dv/max_credit_decrement_scheduler_core_test.sv
`timescale 1ns / 100ps

module max_credit_decrement_scheduler_core_test;
   import mcds_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIRECTED_COUNT = 24;

   typedef struct packed {
      logic [SERVED_W-1:0] served_slot;
      logic                empty_res;
   } grant_type;

   typedef struct packed {
      logic [COMMAND_W-1:0] command;
      logic [CREDIT_W-1:0]  credit;
      logic                 typed;
      grant_type            grant;
   } stim_row_type;

   localparam grant_type EMPTY_GRANT = '{7'd0, 1'b1};
   localparam grant_type ANY_GRANT   = '{7'd0, 1'b0};

   logic clock = 1'b0;
   logic reset;

   mcds_req_if req_bus ();
   mcds_rsp_if rsp_bus ();

   max_credit_decrement_scheduler_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   credit_type tracked_credit [MAX_SLOTS];
   bit         tracked_live   [MAX_SLOTS];
   int         tracked_count;

   grant_type pending_grants [$];
   int        error_count;
   int        quiet_cycles;
   int        calm_left;
   bit        idle_on;

   stim_row_type directed_rows [DIRECTED_COUNT] = '{
      '{CMD_SERVE, 16'h0000, 1'b1, EMPTY_GRANT},
      '{CMD_LOAD,  16'h0000, 1'b0, ANY_GRANT},
      '{CMD_SERVE, 16'hFFFF, 1'b1, '{7'd1, 1'b0}},
      '{CMD_SERVE, 16'h0000, 1'b1, EMPTY_GRANT},
      '{CMD_LOAD,  16'h0001, 1'b0, ANY_GRANT},
      '{CMD_LOAD,  16'h0001, 1'b0, ANY_GRANT},
      '{CMD_SERVE, 16'hFFFF, 1'b0, ANY_GRANT},
      '{CMD_SERVE, 16'h0000, 1'b0, ANY_GRANT},
      '{CMD_SERVE, 16'hFFFF, 1'b1, EMPTY_GRANT},
      '{CMD_LOAD,  16'h0003, 1'b0, ANY_GRANT},
      '{CMD_LOAD,  16'h0002, 1'b0, ANY_GRANT},
      '{CMD_LOAD,  16'h0003, 1'b0, ANY_GRANT},
      '{CMD_SERVE, 16'h0000, 1'b0, ANY_GRANT},
      '{CMD_SERVE, 16'hFFFF, 1'b0, ANY_GRANT},
      '{CMD_SERVE, 16'h0000, 1'b0, ANY_GRANT},
      '{CMD_SERVE, 16'hFFFF, 1'b0, ANY_GRANT},
      '{CMD_SERVE, 16'h0000, 1'b0, ANY_GRANT},
      '{CMD_SERVE, 16'hFFFF, 1'b0, ANY_GRANT},
      '{CMD_SERVE, 16'h0000, 1'b0, ANY_GRANT},
      '{CMD_SERVE, 16'hFFFF, 1'b0, ANY_GRANT},
      '{CMD_SERVE, 16'h0000, 1'b1, EMPTY_GRANT},
      '{CMD_LOAD,  16'h0015, 1'b0, ANY_GRANT},
      '{CMD_LOAD,  16'h002A, 1'b0, ANY_GRANT},
      '{CMD_SERVE, 16'hFFFF, 1'b0, ANY_GRANT}
   };

   task automatic track_item(input logic [COMMAND_W-1:0] cmd, input logic [CREDIT_W-1:0] credit,
                             output bit produced, output grant_type grant);
      int best;
      bit found;
      best = 0;
      found = 1'b0;
      produced = 1'b0;
      grant = ANY_GRANT;
      if (cmd == CMD_LOAD) begin
         if (tracked_count < MAX_SLOTS) begin
            tracked_credit[tracked_count] = credit_type'(credit);
            tracked_live[tracked_count] = 1'b1;
            tracked_count++;
         end
      end else begin
         produced = 1'b1;
         // strict compare keeps the lowest slot on a tie
         for (int i = 0; i < MAX_SLOTS; i++) begin
            if (tracked_live[i] && (!found || tracked_credit[i] > tracked_credit[best])) begin
               best = i;
               found = 1'b1;
            end
         end
         if (!found) begin
            grant = EMPTY_GRANT;
         end else begin
            grant.served_slot = SERVED_W'(best + 1);
            grant.empty_res = 1'b0;
            if (tracked_credit[best] > 1) begin
               tracked_credit[best] = tracked_credit[best] - 1'b1;
            end else begin
               tracked_live[best] = 1'b0;
               tracked_credit[best] = '0;
            end
         end
      end
   endtask

   task automatic send_item(input logic [COMMAND_W-1:0] cmd, input logic [CREDIT_W-1:0] credit,
                            input logic typed, input grant_type typed_grant);
      int gap;
      bit produced;
      grant_type grant;
      @(negedge clock);
      if (idle_on && calm_left == 0 && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         req_bus.valid <= 1'b0;
         req_bus.command <= COMMAND_W'($urandom);
         req_bus.credit <= CREDIT_W'($urandom);
         repeat (gap) @(negedge clock);
      end else if (calm_left > 0) begin
         calm_left--;
      end else if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(10, 60);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.credit <= credit;
      do @(posedge clock); while (!req_bus.ready);
      track_item(cmd, credit, produced, grant);
      if (produced) begin
         pending_grants.insert(pending_grants.size(), typed ? typed_grant : grant);
      end
   endtask

   // result side stalls
   initial begin
      int span;
      rsp_bus.ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            span = $urandom_range(1, 13);
            rsp_bus.ready <= 1'b0;
            repeat (span) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         span = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 30);
         repeat (span) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected transaction: expected none, actual served_slot %0d empty_res %0b",
                     $time, rsp_bus.served_slot, rsp_bus.empty_res);
            error_count++;
         end else begin
            want = pending_grants.pop_front();
            if (rsp_bus.served_slot !== want.served_slot) begin
               $display("%0t: served_slot mismatch: expected %0d actual %0d",
                        $time, want.served_slot, rsp_bus.served_slot);
               error_count++;
            end
            if (rsp_bus.empty_res !== want.empty_res) begin
               $display("%0t: empty_res mismatch: expected %0b actual %0b",
                        $time, want.empty_res, rsp_bus.empty_res);
               error_count++;
            end
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("[max_credit_decrement_scheduler_core] ERROR");
      $finish;
   end

   initial begin
      int n;
      logic [CREDIT_W-1:0] credit_value;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_LOAD;
      req_bus.credit = '0;
      error_count = 0;
      calm_left = 0;
      idle_on = 1'b1;
      tracked_count = 0;
      foreach (tracked_live[i]) begin
         tracked_live[i] = 1'b0;
         tracked_credit[i] = '0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].command, directed_rows[i].credit, directed_rows[i].typed,
                   directed_rows[i].grant);
      end

      // small credits so slots drain and drop out of the live set
      for (n = 0; n < 1150 && tracked_count < MAX_SLOTS - 8; n++) begin
         if ($urandom_range(0, 23) == 0) begin
            credit_value = ($urandom_range(0, 19) == 0) ? CREDIT_W'($urandom_range(0, 255))
                                                         : CREDIT_W'($urandom_range(0, 40));
            send_item(CMD_LOAD, credit_value, 1'b0, ANY_GRANT);
         end else begin
            send_item(CMD_SERVE, CREDIT_W'($urandom), 1'b0, ANY_GRANT);
         end
      end

      // fill the table with wide credits, then loads when full
      for (n = 0; n < 300; n++) begin
         if (n == 150) begin
            idle_on = 1'b0;
         end
         if ((tracked_count < MAX_SLOTS) ? ($urandom_range(0, 3) == 0)
                                         : ($urandom_range(0, 9) == 0)) begin
            credit_value = (tracked_count == MAX_SLOTS - 1) ? 16'hFFFF : CREDIT_W'($urandom);
            send_item(CMD_LOAD, credit_value, 1'b0, ANY_GRANT);
         end else begin
            send_item(CMD_SERVE, CREDIT_W'($urandom), 1'b0, ANY_GRANT);
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (MAX_SLOTS + 16) @(posedge clock);
      if (error_count == 0) begin
         $display("[max_credit_decrement_scheduler_core] OK");
      end else begin
         $display("[max_credit_decrement_scheduler_core] ERROR");
      end
      $finish;
   end

endmodule

>>> max_credit_decrement_scheduler_core.f
rtl/core/mcds_pkg.sv
rtl/core/mcds_req_if.sv
rtl/core/mcds_rsp_if.sv
rtl/core/mcds_credit_ram.sv
rtl/core/mcds_max_track.sv
rtl/core/max_credit_decrement_scheduler_core.sv
dv/max_credit_decrement_scheduler_core_test.sv
